/* hw/rtl/clcd_pkg.sv */
package clcd_pkg;

    // display lines that have a row base
    localparam int LINES = 4;

    // command codes
    localparam logic [1:0] CMD_INSTR  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_INIT   = 2'd2;
    localparam logic [1:0] CMD_SETPOS = 2'd3;

    // register indexes
    localparam logic [2:0] REG_COLUMNS   = 3'd0;
    localparam logic [2:0] REG_ROW0_BASE = 3'd1;
    localparam logic [2:0] REG_ROW1_BASE = 3'd2;
    localparam logic [2:0] REG_ROW2_BASE = 3'd3;
    localparam logic [2:0] REG_ROW3_BASE = 3'd4;

    // register reset values
    localparam logic [5:0] COLUMNS_RST   = 6'd20;
    localparam logic [6:0] ROW0_BASE_RST = 7'h00;
    localparam logic [6:0] ROW1_BASE_RST = 7'h40;
    localparam logic [6:0] ROW2_BASE_RST = 7'h14;
    localparam logic [6:0] ROW3_BASE_RST = 7'h54;

    // set-address flag of the display address instruction
    localparam logic [7:0] ADDR_SET_BIT = 8'h80;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
        logic [7:0] column;
        logic [1:0] line;
    } t_in;

    typedef struct packed {
        logic       target;
        logic [3:0] nibble;
        logic       reg_select;
        logic       enable;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [5:0]      columns;
        logic [3:0][6:0] row_base;
    } t_cfg;

    // one classified byte transfer between front and back
    typedef struct packed {
        logic [7:0] code;
        logic       rs;
        logic       init;
    } t_xfer;

endpackage

/* hw/rtl/char_lcd_nibble_writer.sv */
// a transaction passes the front holding register, the queue and the back output
//   register; set position first runs a bit-serial column modulo in the front
// port writes: 8 per byte transaction and 4 per init, one write per cycle set by
//   the back sequencer while the port write channel is not stalled; the front
//   takes no new transaction while the 8 modulo steps of a set position run
// reset: synchronous active low, queue and sequencer empty, registers to defaults
module char_lcd_nibble_writer import clcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    // port write channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [5:0] r_columns;
    logic [6:0] r_row0_base;
    logic [6:0] r_row1_base;
    logic [6:0] r_row2_base;
    logic [6:0] r_row3_base;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    t_cfg       cfg;

    // front to queue, queue to back
    logic  push;
    t_xfer push_xfer;
    logic  q_full;
    logic  q_valid;
    t_xfer q_head;
    logic  pop;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= COLUMNS_RST;
            r_row0_base <= ROW0_BASE_RST;
            r_row1_base <= ROW1_BASE_RST;
            r_row2_base <= ROW2_BASE_RST;
            r_row3_base <= ROW3_BASE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_COLUMNS:   r_columns   <= pwdata[5:0];
                REG_ROW0_BASE: r_row0_base <= pwdata[6:0];
                REG_ROW1_BASE: r_row1_base <= pwdata[6:0];
                REG_ROW2_BASE: r_row2_base <= pwdata[6:0];
                REG_ROW3_BASE: r_row3_base <= pwdata[6:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_COLUMNS:   prdata = {26'd0, r_columns};
            REG_ROW0_BASE: prdata = {25'd0, r_row0_base};
            REG_ROW1_BASE: prdata = {25'd0, r_row1_base};
            REG_ROW2_BASE: prdata = {25'd0, r_row2_base};
            REG_ROW3_BASE: prdata = {25'd0, r_row3_base};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.columns     = r_columns;
        cfg.row_base[0] = r_row0_base;
        cfg.row_base[1] = r_row1_base;
        cfg.row_base[2] = r_row2_base;
        cfg.row_base[3] = r_row3_base;
    end

    // front: accepts transactions, resolves set position into an address byte
    clcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_xfer     (push_xfer),
        .i_full     (q_full)
    );

    // two-entry queue decouples the modulo unit from the write sequencer
    clcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_xfer),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (pop)
    );

    // back: walks each byte through nibble and enable strobe writes
    clcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/clcd_front.sv */
module clcd_front import clcd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_in   i_in_data,
    output logic  o_push,
    output t_xfer o_xfer,
    input  logic  i_full
);

    typedef enum logic {S_IDLE, S_DIV} t_state;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic [5:0] r_rem;
    logic [7:0] r_col;
    logic [6:0] r_base;
    logic       r_pend;
    t_xfer      r_xfer;

    logic       can_load;
    logic       accept;
    logic [6:0] shifted;
    logic       ge;
    logic [5:0] n_rem;
    logic       n_pend;
    logic [7:0] addr;
    logic [6:0] base;
    t_xfer      direct;
    t_xfer      setpos;

    always_comb begin
        o_push   = r_pend & !i_full;
        can_load = !r_pend | o_push;
        o_in_stall = !((r_state == S_IDLE) && can_load);
        accept   = i_in_valid & !o_in_stall;

        // holding slot refills from a direct transaction or a finished modulo
        n_pend = (r_pend & !o_push)
               | (accept & (i_in_data.command != CMD_SETPOS))
               | ((r_state == S_DIV) & (r_cnt == 3'd7) & can_load);

        // one restoring step of column mod columns, msb first
        shifted = {r_rem, r_col[~r_cnt]};
        ge      = shifted >= {1'b0, i_cfg.columns};
        n_rem   = ge ? 6'(shifted - {1'b0, i_cfg.columns}) : shifted[5:0];
        addr    = (i_cfg.columns == '0) ? r_col : {2'b00, n_rem};

        if (int'(i_in_data.line) < LINES) begin
            base = i_cfg.row_base[i_in_data.line];
        end else begin
            base = '0;
        end

        direct.code = i_in_data.value;
        direct.rs   = (i_in_data.command == CMD_DATA);
        direct.init = (i_in_data.command == CMD_INIT);

        setpos.code = 8'(addr + {1'b0, r_base}) | ADDR_SET_BIT;
        setpos.rs   = 1'b0;
        setpos.init = 1'b0;

        o_xfer = r_xfer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= n_pend;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_data.command == CMD_SETPOS) begin
                            r_state <= S_DIV;
                            r_cnt   <= '0;
                            r_rem   <= '0;
                            r_col   <= i_in_data.column;
                            r_base  <= base;
                        end else begin
                            r_xfer <= direct;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt != 3'd7) begin
                        r_rem <= n_rem;
                        r_cnt <= r_cnt + 3'd1;
                    end else if (can_load) begin
                        r_xfer  <= setpos;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/clcd_fifo.sv */
module clcd_fifo import clcd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_xfer i_din,
    output logic  o_full,
    output logic  o_valid,
    output t_xfer o_head,
    input  logic  i_pop
);

    t_xfer      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_din;
                r_wptr        <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/clcd_back.sv */
module clcd_back import clcd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_xfer i_q_head,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_out  o_out_data
);

    logic       r_active;
    t_xfer      r_entry;
    logic [2:0] r_step;
    logic       r_ovalid;
    t_out       r_out;

    t_xfer      cur;
    logic       cur_valid;
    logic [2:0] step;
    logic       out_free;
    logic       emit;
    logic       is_last;
    t_out       wr;

    always_comb begin
        cur       = r_active ? r_entry : i_q_head;
        cur_valid = r_active | i_q_valid;
        step      = r_active ? r_step : 3'd0;
        out_free  = !r_ovalid | !i_out_stall;
        emit      = cur_valid & out_free;
        o_pop     = emit & !r_active;
        // step[2] picks the low half, step[1:0] walks data, en low, high, low
        is_last   = (step[1:0] == 2'd3) && (step[2] || cur.init);

        wr.target     = (step[1:0] != 2'd0);
        wr.nibble     = '0;
        wr.reg_select = 1'b0;
        wr.enable     = 1'b0;
        wr.last       = is_last;
        if (step[1:0] == 2'd0) begin
            wr.nibble = step[2] ? cur.code[3:0] : cur.code[7:4];
        end else begin
            wr.reg_select = cur.rs;
            wr.enable     = (step[1:0] == 2'd2);
        end

        o_out_valid = r_ovalid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovalid <= emit;
            end
            if (emit) begin
                r_out <= wr;
                if (is_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_active <= 1'b1;
                    r_entry  <= cur;
                    r_step   <= step + 3'd1;
                end
            end
        end
    end

    // an item in progress never sits at its first step
    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_step != 3'd0)
        else $error("active transfer at step zero");

    // an init transfer never reaches the low half
    a_init_high_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_entry.init) |-> !r_step[2])
        else $error("init transfer entered low half");

    // the final write is always the falling enable on the control port
    a_last_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.last) |-> (r_out.target && !r_out.enable))
        else $error("last write is not enable low");

    // queue head is only taken when no transfer is in progress
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_active && i_q_valid))
        else $error("pop while busy or empty");

endmodule
